[rtl/core/ell_pkg.sv]
// Shared types, character codes and token kinds for the expression lexer.
// No dependencies; every other file in rtl/core imports this package.
package ell_pkg;

  // default line length; positions count modulo this value
  localparam int LINE_CHARS_DEF = 4096;

  // width of the offset and length fields of a token
  localparam int OFFSET_W = 12;

  // depth of the token buffer behind the scanner
  localparam int RBUF_DEPTH = 4;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;

  // keyword lengths and the starting progress codes for "true" and "false"
  localparam logic [2:0] TRUE_LEN  = 3'd4;
  localparam logic [2:0] FALSE_LEN = 3'd5;
  localparam logic [3:0] KP_TRUE_START  = 4'd1;
  localparam logic [3:0] KP_FALSE_START = 4'd9;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_IDENT  = 3'd3,
    MODE_OPER   = 3'd4
  } mode_t;

  // token kinds
  typedef enum logic [4:0] {
    KIND_STRING = 5'd0,
    KIND_NUMBER = 5'd1,
    KIND_ADD    = 5'd2,
    KIND_SUB    = 5'd3,
    KIND_MUL    = 5'd4,
    KIND_DIV    = 5'd5,
    KIND_MOD    = 5'd6,
    KIND_LPAREN = 5'd7,
    KIND_RPAREN = 5'd8,
    KIND_LBRACE = 5'd9,
    KIND_RBRACE = 5'd10,
    KIND_AND    = 5'd11,
    KIND_OR     = 5'd12,
    KIND_XOR    = 5'd13,
    KIND_BOOL   = 5'd14,
    KIND_EQ     = 5'd15,
    KIND_NE     = 5'd16,
    KIND_NOT    = 5'd17,
    KIND_ASSIGN = 5'd18,
    KIND_LE     = 5'd19,
    KIND_GE     = 5'd20,
    KIND_LT     = 5'd21,
    KIND_GT     = 5'd22,
    KIND_IDENT  = 5'd23,
    KIND_BAD    = 5'd24,
    KIND_UNTERM = 5'd25
  } kind_t;

  // input word: one character of the line
  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } char_word_t;

  // output word: one token
  typedef struct packed {
    logic [4:0]          token_kind;
    logic [OFFSET_W-1:0] start_offset;
    logic [OFFSET_W-1:0] token_length;
    logic                run_last;
  } tok_word_t;

  // tokens produced by one character, handed from scanner to buffer
  // (a closed token, a new one-character token or operator, and a line-end flush)
  typedef struct packed {
    logic [1:0]           count;
    tok_word_t [2:0]      slot;
  } step_res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word_char(logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_UNDER);
  endfunction

  // kind of a pending operator that stands alone
  function automatic kind_t single_kind(logic [7:0] op);
    kind_t k;
    case (op)
      CH_EQUAL: k = KIND_ASSIGN;
      CH_BANG:  k = KIND_NOT;
      CH_LESS:  k = KIND_LT;
      CH_GREAT: k = KIND_GT;
      default:  k = KIND_BAD;
    endcase
    return k;
  endfunction

  // kind of a two-character operator; KIND_BAD when the pair is none
  function automatic kind_t pair_kind(logic [7:0] op, logic [7:0] c);
    kind_t k;
    k = KIND_BAD;
    if ((op == CH_AMP) && (c == CH_AMP)) k = KIND_AND;
    else if ((op == CH_PIPE) && (c == CH_PIPE)) k = KIND_OR;
    else if ((op == CH_CARET) && (c == CH_CARET)) k = KIND_XOR;
    else if (c == CH_EQUAL) begin
      case (op)
        CH_EQUAL: k = KIND_EQ;
        CH_BANG:  k = KIND_NE;
        CH_LESS:  k = KIND_LE;
        CH_GREAT: k = KIND_GE;
        default:  k = KIND_BAD;
      endcase
    end
    return k;
  endfunction

  // letter at index idx of "true" or, with is_false, of "false"
  function automatic logic [7:0] kw_char(logic is_false, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_false) begin
      case (idx)
        3'd0:    ch = 8'h66;
        3'd1:    ch = 8'h61;
        3'd2:    ch = 8'h6C;
        3'd3:    ch = 8'h73;
        3'd4:    ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    ch = 8'h74;
        3'd1:    ch = 8'h72;
        3'd2:    ch = 8'h75;
        3'd3:    ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

[rtl/core/ell_scan.sv]
// Scanner: lexer state registers and the per-character next-state logic.
// Depends on ell_pkg for modes, kinds, character codes and word types.
module ell_scan #(
  parameter int LINE_CHARS = ell_pkg::LINE_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  ell_pkg::char_word_t    word,
  output ell_pkg::step_res_t     result
);
  import ell_pkg::*;

  localparam int POS_W  = $clog2(LINE_CHARS);
  localparam int SPAN_W = POS_W + 1;
  localparam int EXT_W  = (SPAN_W > OFFSET_W) ? SPAN_W : OFFSET_W;

  typedef logic [POS_W-1:0] pos_t;

  mode_t      mode, mode_next;
  pos_t       position, position_next;
  pos_t       token_start, token_start_next;
  logic       dot_seen, dot_seen_next;
  logic [3:0] keyword_progress, keyword_progress_next;
  logic [7:0] pending_operator, pending_operator_next;

  logic [7:0]        c;
  logic              last;
  logic              fresh;
  logic [1:0]        cnt;
  step_res_t         res;
  logic [2:0]        kw_cnt, kw_cnt_inc, kw_len;
  logic              kw_false;
  kind_t             pk;
  logic [SPAN_W-1:0] flush_len;

  // next position with wrap at the line length
  function automatic pos_t wrap_inc(pos_t p);
    return (p == POS_W'(LINE_CHARS - 1)) ? '0 : p + 1'b1;
  endfunction

  // distance from one position to another, modulo the line length
  function automatic logic [SPAN_W-1:0] span(pos_t from, pos_t to);
    logic [SPAN_W-1:0] f, t;
    f = {1'b0, from};
    t = {1'b0, to};
    return (to >= from) ? (t - f) : (t + SPAN_W'(LINE_CHARS) - f);
  endfunction

  // fit a position-sized value into an offset field
  function automatic logic [OFFSET_W-1:0] fit(logic [SPAN_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[OFFSET_W-1:0];
  endfunction

  function automatic tok_word_t mk(kind_t k, pos_t start, logic [SPAN_W-1:0] len);
    tok_word_t t;
    t.token_kind   = k;
    t.start_offset = fit({1'b0, start});
    t.token_length = fit(len);
    t.run_last     = 1'b0;
    return t;
  endfunction

  // next state and tokens for the current character
  always_comb begin
    c    = word.character;
    last = word.line_end;
    mode_next             = mode;
    position_next         = position;
    token_start_next      = token_start;
    dot_seen_next         = dot_seen;
    keyword_progress_next = keyword_progress;
    pending_operator_next = pending_operator;
    fresh      = 1'b0;
    cnt        = 2'd0;
    res        = '0;
    kw_cnt     = keyword_progress[2:0];
    kw_false   = keyword_progress[3];
    kw_len     = kw_false ? FALSE_LEN : TRUE_LEN;
    kw_cnt_inc = kw_cnt + 3'd1;
    pk         = pair_kind(pending_operator, c);

    // continue or close the open token
    unique case (mode)
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          res.slot[cnt] = mk(KIND_STRING, token_start, span(token_start, position));
          cnt = cnt + 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          mode_next = MODE_NUMBER;
        end else if ((c == CH_DOT) && !dot_seen) begin
          dot_seen_next = 1'b1;
        end else begin
          res.slot[cnt] = mk(KIND_NUMBER, token_start, span(token_start, position));
          cnt = cnt + 2'd1;
          mode_next = MODE_IDLE;
          fresh = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_word_char(c)) begin
          // track a true or false prefix
          if (kw_cnt != 3'd0) begin
            if ((kw_cnt < kw_len) && (c == kw_char(kw_false, kw_cnt))) begin
              if (kw_cnt_inc == kw_len) begin
                res.slot[cnt] = mk(KIND_BOOL, token_start, SPAN_W'(kw_len));
                cnt = cnt + 2'd1;
                mode_next = MODE_IDLE;
                keyword_progress_next = '0;
              end else begin
                keyword_progress_next = {kw_false, kw_cnt_inc};
              end
            end else begin
              keyword_progress_next = '0;
            end
          end
        end else begin
          res.slot[cnt] = mk(KIND_IDENT, token_start, span(token_start, position));
          cnt = cnt + 2'd1;
          mode_next = MODE_IDLE;
          keyword_progress_next = '0;
          fresh = 1'b1;
        end
      end
      MODE_OPER: begin
        if (pk != KIND_BAD) begin
          res.slot[cnt] = mk(pk, token_start, SPAN_W'(2));
          cnt = cnt + 2'd1;
        end else begin
          res.slot[cnt] = mk(single_kind(pending_operator), token_start, SPAN_W'(1));
          cnt = cnt + 2'd1;
          fresh = 1'b1;
        end
        mode_next = MODE_IDLE;
        pending_operator_next = '0;
      end
      default: begin
        mode_next = MODE_IDLE;
        fresh = 1'b1;
      end
    endcase

    // character starts something new
    if (fresh) begin
      if ((c == CH_TAB) || (c == CH_NL) || (c == CH_SPACE)) begin
        mode_next = MODE_IDLE;
      end else if (c == CH_QUOTE) begin
        mode_next = MODE_STRING;
        token_start_next = wrap_inc(position);
      end else if (is_digit(c)) begin
        mode_next = MODE_NUMBER;
        token_start_next = position;
        dot_seen_next = 1'b0;
      end else begin
        unique case (c)
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT,
          CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: begin
            unique case (c)
              CH_PLUS:   res.slot[cnt] = mk(KIND_ADD, position, SPAN_W'(1));
              CH_MINUS:  res.slot[cnt] = mk(KIND_SUB, position, SPAN_W'(1));
              CH_STAR:   res.slot[cnt] = mk(KIND_MUL, position, SPAN_W'(1));
              CH_SLASH:  res.slot[cnt] = mk(KIND_DIV, position, SPAN_W'(1));
              CH_PCT:    res.slot[cnt] = mk(KIND_MOD, position, SPAN_W'(1));
              CH_LPAREN: res.slot[cnt] = mk(KIND_LPAREN, position, SPAN_W'(1));
              CH_RPAREN: res.slot[cnt] = mk(KIND_RPAREN, position, SPAN_W'(1));
              CH_LBRACE: res.slot[cnt] = mk(KIND_LBRACE, position, SPAN_W'(1));
              default:   res.slot[cnt] = mk(KIND_RBRACE, position, SPAN_W'(1));
            endcase
            cnt = cnt + 2'd1;
          end
          CH_AMP, CH_PIPE, CH_CARET, CH_EQUAL, CH_BANG, CH_LESS, CH_GREAT: begin
            mode_next = MODE_OPER;
            pending_operator_next = c;
            token_start_next = position;
          end
          default: begin
            if (is_letter(c) || (c == CH_UNDER)) begin
              mode_next = MODE_IDENT;
              token_start_next = position;
              keyword_progress_next = (c == CH_LOW_T) ? KP_TRUE_START :
                                      (c == CH_LOW_F) ? KP_FALSE_START : 4'd0;
            end else begin
              res.slot[cnt] = mk(KIND_BAD, position, SPAN_W'(1));
              cnt = cnt + 2'd1;
            end
          end
        endcase
      end
    end

    // line end flushes whatever is still open
    flush_len = span(token_start_next, wrap_inc(position));
    if (last) begin
      unique case (mode_next)
        MODE_STRING: begin
          res.slot[cnt] = mk(KIND_UNTERM, token_start_next, flush_len);
          cnt = cnt + 2'd1;
        end
        MODE_NUMBER: begin
          res.slot[cnt] = mk(KIND_NUMBER, token_start_next, flush_len);
          cnt = cnt + 2'd1;
        end
        MODE_IDENT: begin
          res.slot[cnt] = mk(KIND_IDENT, token_start_next, flush_len);
          cnt = cnt + 2'd1;
        end
        MODE_OPER: begin
          res.slot[cnt] = mk(single_kind(pending_operator_next), token_start_next,
                             SPAN_W'(1));
          cnt = cnt + 2'd1;
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
      mode_next             = MODE_IDLE;
      pending_operator_next = '0;
      keyword_progress_next = '0;
      dot_seen_next         = 1'b0;
      position_next         = '0;
    end else begin
      position_next = wrap_inc(position);
    end

    // mark the final token of this character
    if (cnt == 2'd3) res.slot[2].run_last = 1'b1;
    else if (cnt == 2'd2) res.slot[1].run_last = 1'b1;
    else if (cnt == 2'd1) res.slot[0].run_last = 1'b1;
    res.count = cnt;
  end

  assign result = res;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      position         <= '0;
      token_start      <= '0;
      dot_seen         <= 1'b0;
      keyword_progress <= '0;
      pending_operator <= '0;
    end else if (step) begin
      mode             <= mode_next;
      position         <= position_next;
      token_start      <= token_start_next;
      dot_seen         <= dot_seen_next;
      keyword_progress <= keyword_progress_next;
      pending_operator <= pending_operator_next;
    end
  end

endmodule

[rtl/core/ell_rbuf.sv]
// Token buffer: queue taking up to three tokens a cycle, giving one when ready.
// Depends on ell_pkg for the token word and step result types.
module ell_rbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ell_pkg::step_res_t   result,
  output logic                 room,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output ell_pkg::tok_word_t   tok_word
);
  import ell_pkg::*;

  localparam int PTR_W = $clog2(RBUF_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  tok_word_t          entry [RBUF_DEPTH];
  logic [PTR_W-1:0]   head, tail;
  logic [CNT_W-1:0]   count;
  logic [1:0]         push_n;
  logic               pop;

  assign push_n    = push ? result.count : 2'd0;
  assign pop       = tok_valid && tok_ready;
  assign tok_valid = (count != '0);
  assign tok_word  = entry[head];
  // room for the worst case of three tokens from one character
  assign room      = (count <= CNT_W'(RBUF_DEPTH - 3));

  // token storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entry[tail] <= result.slot[0];
    if (push_n >= 2'd2) entry[tail + PTR_W'(1)] <= result.slot[1];
    if (push_n == 2'd3) entry[tail + PTR_W'(2)] <= result.slot[2];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_W'(push_n);
      head  <= head + PTR_W'(pop);
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

endmodule

[rtl/core/expression_language_lexer.sv]
// A character accepted into the input register is scanned once the token queue has room; its tokens go into the queue.
// Throughput: one character per cycle in and one token per cycle out while tok_ready is high;
//   a character is scanned only while at most one token waits in the queue.
// The rate is set by the combinational scanner step and the four-entry token queue.
// Reset (rst, synchronous): scanner idle at position 0, queue and input register empty.
// Depends on ell_pkg, ell_scan and ell_rbuf.
module expression_language_lexer #(
  parameter int LINE_CHARS = ell_pkg::LINE_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  ell_pkg::char_word_t  char_word,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output ell_pkg::tok_word_t   tok_word
);
  import ell_pkg::*;

  logic       in_full;
  char_word_t in_word;
  logic       room;
  logic       step;
  step_res_t  result;

  // the held character is scanned when the queue has room for three tokens
  assign step       = in_full && room;
  assign char_ready = !in_full || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_valid && char_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) in_word <= char_word;
  end

  ell_scan #(
    .LINE_CHARS (LINE_CHARS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .word   (in_word),
    .result (result)
  );

  ell_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .result    (result),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_word  (tok_word)
  );

endmodule

[rtl/core/ell_chk.sv]
// Port-level checks for the expression lexer, bound to the top level.
// Depends on ell_pkg for token kinds and word types.
module ell_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 char_valid,
  input logic                 char_ready,
  input ell_pkg::char_word_t  char_word,
  input logic                 tok_valid,
  input logic                 tok_ready,
  input ell_pkg::tok_word_t   tok_word
);
  import ell_pkg::*;

  // a stalled token holds
  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_word))
    else $error("token changed while stalled");

  // no token right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("token shown after reset");

  // one-character tokens have length one
  a_single_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_word.token_kind == KIND_ADD || tok_word.token_kind == KIND_SUB ||
                  tok_word.token_kind == KIND_MUL || tok_word.token_kind == KIND_DIV ||
                  tok_word.token_kind == KIND_MOD || tok_word.token_kind == KIND_LPAREN ||
                  tok_word.token_kind == KIND_RPAREN || tok_word.token_kind == KIND_LBRACE ||
                  tok_word.token_kind == KIND_RBRACE || tok_word.token_kind == KIND_BAD ||
                  tok_word.token_kind == KIND_NOT || tok_word.token_kind == KIND_ASSIGN ||
                  tok_word.token_kind == KIND_LT || tok_word.token_kind == KIND_GT)
    |-> tok_word.token_length == 12'd1)
    else $error("single-character token with wrong length");

  // two-character operators have length two
  a_pair_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_word.token_kind == KIND_AND || tok_word.token_kind == KIND_OR ||
                  tok_word.token_kind == KIND_XOR || tok_word.token_kind == KIND_EQ ||
                  tok_word.token_kind == KIND_NE || tok_word.token_kind == KIND_LE ||
                  tok_word.token_kind == KIND_GE)
    |-> tok_word.token_length == 12'd2)
    else $error("two-character operator with wrong length");

  // booleans are exactly true or false
  a_bool_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_word.token_kind == KIND_BOOL
    |-> tok_word.token_length == 12'd4 || tok_word.token_length == 12'd5)
    else $error("boolean with wrong length");

endmodule

bind expression_language_lexer ell_chk u_chk (.*);

[dv/tb_top.sv]
// Self-checking testbench for expression_language_lexer: drives lines of text and checks each token.
// A predictor inside the bench computes the expected token words for every accepted character.
// Depends on ell_pkg and the expression_language_lexer RTL.
`timescale 1ns / 1ps

module tb_top;
  import ell_pkg::*;

  typedef logic [7:0] chars_t[$];

  // clock, reset and block ports
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_word_t char_word = '0;
  logic       tok_valid;
  logic       tok_ready = 1'b0;
  tok_word_t  tok_word;

  // run bookkeeping
  bit         idle_on = 1'b1;
  int         err_count = 0;
  int         chars_sent = 0;
  int         lines_sent = 0;
  int         toks_checked = 0;

  // predictor state
  mode_t       lx_mode;
  logic [11:0] lx_pos;
  logic [11:0] lx_begin;
  logic        lx_dot;
  logic [3:0]  lx_kw;
  logic [7:0]  lx_op;
  tok_word_t   step_toks[$];
  tok_word_t   tok_expected[$];

  expression_language_lexer dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_word  (char_word),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_word   (tok_word)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // character classes
  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit name_ch(logic [7:0] c);
    return letter_ch(c) || digit_ch(c) || c == CH_MINUS || c == CH_UNDER;
  endfunction

  // operator held alone
  function automatic kind_t lone_op_kind(logic [7:0] op);
    case (op)
      CH_EQUAL: return KIND_ASSIGN;
      CH_BANG:  return KIND_NOT;
      CH_LESS:  return KIND_LT;
      CH_GREAT: return KIND_GT;
      default:  return KIND_BAD;
    endcase
  endfunction

  // held operator plus next char; bad kind means no pair
  function automatic kind_t op_pair_kind(logic [7:0] op, logic [7:0] c);
    if (op == c && (c == CH_AMP || c == CH_PIPE || c == CH_CARET)) begin
      return (c == CH_AMP) ? KIND_AND : (c == CH_PIPE) ? KIND_OR : KIND_XOR;
    end
    if (c != CH_EQUAL) return KIND_BAD;
    case (op)
      CH_EQUAL: return KIND_EQ;
      CH_BANG:  return KIND_NE;
      CH_LESS:  return KIND_LE;
      CH_GREAT: return KIND_GE;
      default:  return KIND_BAD;
    endcase
  endfunction

  function automatic void add_tok(kind_t k, logic [11:0] s, logic [11:0] n);
    tok_word_t t;
    t.token_kind   = k;
    t.start_offset = s;
    t.token_length = n;
    t.run_last     = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void lex_reset();
    lx_mode  = MODE_IDLE;
    lx_pos   = '0;
    lx_begin = '0;
    lx_dot   = 1'b0;
    lx_kw    = '0;
    lx_op    = '0;
  endfunction

  // first char of a new token
  function automatic void lex_start(logic [7:0] c, logic [11:0] p);
    case (c)
      CH_TAB, CH_NL, CH_SPACE: begin
      end
      CH_QUOTE: begin
        lx_mode  = MODE_STRING;
        lx_begin = p + 12'd1;
      end
      CH_PLUS:   add_tok(KIND_ADD, p, 12'd1);
      CH_MINUS:  add_tok(KIND_SUB, p, 12'd1);
      CH_STAR:   add_tok(KIND_MUL, p, 12'd1);
      CH_SLASH:  add_tok(KIND_DIV, p, 12'd1);
      CH_PCT:    add_tok(KIND_MOD, p, 12'd1);
      CH_LPAREN: add_tok(KIND_LPAREN, p, 12'd1);
      CH_RPAREN: add_tok(KIND_RPAREN, p, 12'd1);
      CH_LBRACE: add_tok(KIND_LBRACE, p, 12'd1);
      CH_RBRACE: add_tok(KIND_RBRACE, p, 12'd1);
      CH_AMP, CH_PIPE, CH_CARET, CH_EQUAL, CH_BANG, CH_LESS, CH_GREAT: begin
        lx_mode  = MODE_OPER;
        lx_op    = c;
        lx_begin = p;
      end
      default: begin
        if (digit_ch(c)) begin
          lx_mode  = MODE_NUMBER;
          lx_begin = p;
          lx_dot   = 1'b0;
        end else if (letter_ch(c) || c == CH_UNDER) begin
          lx_mode  = MODE_IDENT;
          lx_begin = p;
          lx_kw    = (c == CH_LOW_T) ? KP_TRUE_START : (c == CH_LOW_F) ? KP_FALSE_START : 4'd0;
        end else begin
          add_tok(KIND_BAD, p, 12'd1);
        end
      end
    endcase
  endfunction

  // expected tokens for one accepted character
  function automatic void lex_char(char_word_t w);
    logic [7:0] c;
    bit         fresh;
    logic [2:0] cnt;
    logic [2:0] wl;
    bit         isf;
    string      kw;
    kind_t      k;
    c = w.character;
    fresh = 1'b0;
    step_toks.delete();
    case (lx_mode)
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          add_tok(KIND_STRING, lx_begin, lx_pos - lx_begin);
          lx_mode = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (digit_ch(c)) begin
        end else if (c == CH_DOT && !lx_dot) begin
          lx_dot = 1'b1;
        end else begin
          add_tok(KIND_NUMBER, lx_begin, lx_pos - lx_begin);
          lx_mode = MODE_IDLE;
          fresh = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (name_ch(c)) begin
          // track a true/false prefix while the word goes on
          cnt = lx_kw[2:0];
          if (cnt != 3'd0) begin
            isf = lx_kw[3];
            kw  = isf ? "false" : "true";
            wl  = isf ? FALSE_LEN : TRUE_LEN;
            if (cnt < wl && c == kw[cnt]) begin
              cnt = cnt + 3'd1;
              if (cnt == wl) begin
                add_tok(KIND_BOOL, lx_begin, 12'(wl));
                lx_mode = MODE_IDLE;
                lx_kw   = '0;
              end else begin
                lx_kw = {isf, cnt};
              end
            end else begin
              lx_kw = '0;
            end
          end
        end else begin
          add_tok(KIND_IDENT, lx_begin, lx_pos - lx_begin);
          lx_mode = MODE_IDLE;
          lx_kw   = '0;
          fresh   = 1'b1;
        end
      end
      MODE_OPER: begin
        k = op_pair_kind(lx_op, c);
        if (k != KIND_BAD) begin
          add_tok(k, lx_begin, 12'd2);
        end else begin
          add_tok(lone_op_kind(lx_op), lx_begin, 12'd1);
          fresh = 1'b1;
        end
        lx_mode = MODE_IDLE;
        lx_op   = '0;
      end
      default: fresh = 1'b1;
    endcase

    if (fresh) lex_start(c, lx_pos);

    // line end flushes whatever is open
    if (w.line_end) begin
      case (lx_mode)
        MODE_STRING: add_tok(KIND_UNTERM, lx_begin, lx_pos + 12'd1 - lx_begin);
        MODE_NUMBER: add_tok(KIND_NUMBER, lx_begin, lx_pos + 12'd1 - lx_begin);
        MODE_IDENT:  add_tok(KIND_IDENT, lx_begin, lx_pos + 12'd1 - lx_begin);
        MODE_OPER:   add_tok(lone_op_kind(lx_op), lx_begin, 12'd1);
        default: begin
        end
      endcase
      lx_mode = MODE_IDLE;
      lx_op   = '0;
      lx_kw   = '0;
      lx_dot  = 1'b0;
      lx_pos  = '0;
    end else begin
      lx_pos = lx_pos + 12'd1;
    end

    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].run_last = 1'b1;
    foreach (step_toks[i]) tok_expected.push_back(step_toks[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    tok_word_t want;
    if (!rst && tok_valid && tok_ready) begin
      toks_checked++;
      if (tok_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d start %0d len %0d",
                                  tok_word.token_kind, tok_word.start_offset,
                                  tok_word.token_length));
      end else begin
        want = tok_expected.pop_front();
        if (tok_word.token_kind != want.token_kind)
          report_mismatch($sformatf("token_kind %0d, expected %0d",
                                    tok_word.token_kind, want.token_kind));
        if (tok_word.start_offset != want.start_offset)
          report_mismatch($sformatf("start_offset %0d, expected %0d (kind %0d)",
                                    tok_word.start_offset, want.start_offset, want.token_kind));
        if (tok_word.token_length != want.token_length)
          report_mismatch($sformatf("token_length %0d, expected %0d (kind %0d)",
                                    tok_word.token_length, want.token_length, want.token_kind));
        if (tok_word.run_last != want.run_last)
          report_mismatch($sformatf("run_last %0d, expected %0d (kind %0d)",
                                    tok_word.run_last, want.run_last, want.token_kind));
      end
    end
  end

  // receiver: random stall bursts, long ready stretches
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        tok_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      tok_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // send one word, with an occasional gap in front
  task automatic send_char(char_word_t w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= w;
    do @(posedge clk); while (!char_ready);
    lex_char(w);
    chars_sent++;
  endtask

  task automatic send_line(chars_t q);
    char_word_t w;
    foreach (q[i]) begin
      w.character = q[i];
      w.line_end  = (i == q.size() - 1);
      send_char(w);
    end
    lines_sent++;
  endtask

  function automatic chars_t str_chars(string s);
    chars_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // stop sending until every expected token is out
  task automatic drain_tokens();
    char_valid <= 1'b0;
    while (tok_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one random token, mostly well formed
  function automatic chars_t gen_token();
    string  ops[23] = '{"+", "-", "*", "/", "%", "(", ")", "{", "}", "&&", "||", "^^",
                        "==", "!=", "<=", ">=", "=", "!", "<", ">", "&", "|", "^"};
    string  heads[7] = '{"true", "false", "tru", "fals", "t", "f", "_"};
    string  wchars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";
    chars_t q;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 1)) begin
          q.push_back(CH_DOT);
          repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range("0", "9")));
          if ($urandom_range(0, 5) == 0) q.push_back(CH_DOT);
        end
      end
      2: begin
        q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          q.push_back(c == CH_QUOTE ? CH_SPACE : c);
        end
        if ($urandom_range(0, 9) != 0) q.push_back(CH_QUOTE);
      end
      3, 4: begin
        if ($urandom_range(0, 2) == 0) q.push_back(wchars[$urandom_range(0, 51)]);
        else q = str_chars(heads[$urandom_range(0, 6)]);
        repeat ($urandom_range(0, 4)) q.push_back(wchars[$urandom_range(0, 63)]);
      end
      5, 6, 7, 8: q = str_chars(ops[$urandom_range(0, 22)]);
      default: q.push_back(8'($urandom_range(0, 255)));
    endcase
    return q;
  endfunction

  // every operator, one and two chars
  task automatic test_operators();
    chars_t q;
    send_line(str_chars("+-*/%(){}&&||^^==!=<=>="));
    // single ops, whitespace, null and high byte, lone amp at line end
    q = str_chars("=!<>\t\n ");
    q.push_back(8'h00);
    q.push_back(8'hFF);
    q.push_back(CH_AMP);
    send_line(q);
  endtask

  // strings, second dot, keyword prefixes, quote at line end
  task automatic test_special_cases();
    send_line(str_chars("\"a\"1.2.falsey\""));
    send_line(str_chars("truex9."));
  endtask

  // random lines of tokens, with some pure noise lines
  task automatic test_random_lines();
    chars_t line;
    chars_t t;
    int     target;
    int     counted;
    bit     paused;
    counted = 0;
    paused = 1'b0;
    while (counted < 1000) begin
      line.delete();
      target = $urandom_range(1, 40);
      if ($urandom_range(0, 7) == 0) begin
        repeat (target) line.push_back(8'($urandom_range(0, 255)));
      end else begin
        while (line.size() < target) begin
          t = gen_token();
          foreach (t[j]) line.push_back(t[j]);
          if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 2)) begin
              case ($urandom_range(0, 3))
                0:       line.push_back(CH_TAB);
                1:       line.push_back(CH_NL);
                default: line.push_back(CH_SPACE);
              endcase
            end
          end
        end
      end
      counted += line.size();
      send_line(line);
      if (!paused && counted > 500) begin
        drain_tokens();
        paused = 1'b1;
      end
      // the tail of the run goes at full rate
      if (counted > 880) idle_on = 1'b0;
    end
  endtask

  initial begin
    lex_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_operators();
    test_special_cases();
    test_random_lines();
    char_valid <= 1'b0;
    while (tok_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("ran %0d characters over %0d lines of operators, strings, numbers and noise",
             chars_sent, lines_sent);
    $display("checked %0d tokens, %0d mismatches", toks_checked, err_count);
    if (err_count == 0 && tok_expected.size() == 0) begin
      $display("PASS expression_language_lexer");
    end else begin
      $display("FAIL expression_language_lexer");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d tokens outstanding", tok_expected.size());
    $display("FAIL expression_language_lexer");
    $finish;
  end

endmodule

[expression_language_lexer.f]
rtl/core/ell_pkg.sv
rtl/core/ell_scan.sv
rtl/core/ell_rbuf.sv
rtl/core/expression_language_lexer.sv
rtl/core/ell_chk.sv
dv/tb_top.sv
